[sv/lhl_pkg.sv]
// ----------------------------------------------------------------------------
// lhl_pkg: shared types and constants of the layer hit likelihood block
// Fixed-point format, layer counts, outcome and row codes, and the structs
// that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package lhl_pkg;

    // Fixed point: unsigned, FRACTION_BITS fraction bits, 1.0 = ONE_FX.
    localparam int FRACTION_BITS = 16;
    localparam int PROB_W        = 17;
    localparam logic [PROB_W-1:0] ONE_FX = PROB_W'(1 << FRACTION_BITS);

    // Layer geometry.
    localparam int MAX_BARREL_LAYER   = 14;
    localparam int MAX_FORWARD_LAYER  = 13;
    localparam int MAX_BACKWARD_LAYER = 11;
    localparam int BARREL_LAYERS      = MAX_BARREL_LAYER + 1;
    localparam int LAYER_COUNT        = 29;
    localparam int LAST_POS           = LAYER_COUNT - 1;

    // Table geometry: row * 512 + last * 32 + layer.
    localparam int ROW_W      = 7;
    localparam int LAST_W     = 4;
    localparam int LAYER_W    = 5;
    localparam int ADDR_W     = ROW_W + LAST_W + LAYER_W;
    localparam int ROWS       = 67;
    localparam int TABLE_DEPTH = ROWS * (1 << LAST_W) * (1 << LAYER_W);

    // Item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_TRACK = 1'b1;

    // Raw outcome codes.
    localparam logic [2:0] OUT_NONE        = 3'd0;
    localparam logic [2:0] OUT_BARREL_STOP = 3'd1;
    localparam logic [2:0] OUT_ENDCAP_STOP = 3'd2;
    localparam logic [2:0] OUT_BARREL_EXIT = 3'd3;
    localparam logic [2:0] OUT_ENDCAP_EXIT = 3'd4;

    // Refined rows for endcap tracks with no barrel layer crossed.
    localparam logic [ROW_W-1:0] ROW_FWD_STOP = 7'd2;
    localparam logic [ROW_W-1:0] ROW_FWD_EXIT = 7'd4;
    localparam logic [ROW_W-1:0] ROW_BWD_STOP = 7'd5;
    localparam logic [ROW_W-1:0] ROW_BWD_EXIT = 7'd6;

    // Row bases for endcap tracks that also crossed barrel layers.
    localparam logic [ROW_W-1:0] ROW_FWD_STOP_BASE = 7'd7;
    localparam logic [ROW_W-1:0] ROW_BWD_STOP_BASE = 7'd22;
    localparam logic [ROW_W-1:0] ROW_FWD_EXIT_BASE = 7'd37;
    localparam logic [ROW_W-1:0] ROW_BWD_EXIT_BASE = 7'd52;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_REPORT
    } lhl_state_t;

    // What one layer contributes to the running product.
    typedef enum logic [1:0] {
        ACT_SKIP,
        ACT_HIT,
        ACT_MISS
    } layer_act_t;

    typedef struct packed {
        logic load;
        logic capture;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic reject;
        logic walk_last;
    } dp_status_t;

endpackage

[sv/layer_hit_likelihood.sv]
// ----------------------------------------------------------------------------
// layer_hit_likelihood: per-layer hit likelihood of a track
// Loads a table of per-layer hit probabilities and, for each track, forms
// the product of the hit, miss or neighbor factors of its crossed layers.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// item      in         start & !busy          kind, track_outcome,
//                                             barrel_last_layer, endcap_last_layer,
//                                             crossed_pattern, hit_pattern, is_forward,
//                                             entry_outcome, entry_last_layer,
//                                             entry_layer, entry_probability
// result    out        done (one-cycle pulse) likelihood, rejected
//
// A load item writes its entry at the accepting edge and busy stays low, so
// loads can follow each other in every cycle while the block is idle. A
// track walks its layer positions in the walk state (one table read per
// layer position, set by the single read port of the table), finishes the
// last multiply in the drain state and shows its result in the report state
// with done high. busy drops after the result cycle, so a track is taken
// only after the last has shown its result. A track that fails the outcome
// or layer checks leaves the walk at its first position for the report state.
// Reset clears the controller and the walk control only. The 34304-entry
// table has no clearing pass; an entry is meaningful once it was loaded.
// The receiver cannot stall: each result is valid only while done is high.
//
module layer_hit_likelihood
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               kind,
    input  logic [2:0]         track_outcome,
    input  logic signed [4:0]  barrel_last_layer,
    input  logic signed [4:0]  endcap_last_layer,
    input  logic [28:0]        crossed_pattern,
    input  logic [28:0]        hit_pattern,
    input  logic               is_forward,
    input  logic [6:0]         entry_outcome,
    input  logic [3:0]         entry_last_layer,
    input  logic [4:0]         entry_layer,
    input  logic [16:0]        entry_probability,
    output logic               done,
    output logic [16:0]        likelihood,
    output logic               rejected
);
    import lhl_pkg::*;

    // Commands from the controller and status back from the datapath.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The controller decides when items are taken and when the walk ends.
    lhl_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // The datapath owns the table, the operands and the running product.
    // The result ports come straight from its registers, so they hold still
    // during the whole result cycle.
    lhl_dpath u_dpath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .track_outcome     (track_outcome),
        .barrel_last_layer (barrel_last_layer),
        .endcap_last_layer (endcap_last_layer),
        .crossed_pattern   (crossed_pattern),
        .hit_pattern       (hit_pattern),
        .is_forward        (is_forward),
        .entry_outcome     (entry_outcome),
        .entry_last_layer  (entry_last_layer),
        .entry_layer       (entry_layer),
        .entry_probability (entry_probability),
        .status            (status),
        .likelihood        (likelihood),
        .rejected          (rejected)
    );

endmodule

[sv/lhl_ctrl.sv]
// ----------------------------------------------------------------------------
// lhl_ctrl: sequencing state machine of the layer hit likelihood block
// Takes items, steps the datapath over the layer positions and raises the
// result strobe.
// ----------------------------------------------------------------------------
module lhl_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               kind,
    input  lhl_pkg::dp_status_t status,
    output lhl_pkg::ctrl_cmd_t  cmd,
    output logic               busy,
    output logic               done
);
    import lhl_pkg::*;

    lhl_state_t state_reg;
    lhl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (kind == KIND_TRACK))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.reject)
                begin
                    state_next = ST_REPORT;
                end
                else if (status.walk_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.load    = start && (kind == KIND_LOAD);
                cmd.capture = start && (kind == KIND_TRACK);
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.step = 1'b0;
            end
            ST_REPORT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // A result is shown for one cycle and the block is then free again.
    a_report_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REPORT |=> state_reg == ST_IDLE)
        else $error("result strobe not followed by idle");

    // An accepted evaluate item always starts the layer walk.
    a_capture_walks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_WALK)
        else $error("evaluate item did not start the walk");

    // The drain cycle only follows the last walk position.
    a_drain_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |-> $past(state_reg) == ST_WALK && $past(status.walk_last))
        else $error("drain entered before the walk finished");

    // No item is taken while the block works on one.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.load && !cmd.capture)
        else $error("item accepted while busy");

endmodule

[sv/lhl_dpath.sv]
// ----------------------------------------------------------------------------
// lhl_dpath: datapath of the layer hit likelihood block
// Holds the probability table, the track operands, the layer position
// counter, and the multiply stage that builds the running product.
// ----------------------------------------------------------------------------
module lhl_dpath
(
    input  logic                clk,
    input  logic                rst_n,
    input  lhl_pkg::ctrl_cmd_t  cmd,
    input  logic [2:0]          track_outcome,
    input  logic signed [4:0]   barrel_last_layer,
    input  logic signed [4:0]   endcap_last_layer,
    input  logic [28:0]         crossed_pattern,
    input  logic [28:0]         hit_pattern,
    input  logic                is_forward,
    input  logic [6:0]          entry_outcome,
    input  logic [3:0]          entry_last_layer,
    input  logic [4:0]          entry_layer,
    input  logic [16:0]         entry_probability,
    output lhl_pkg::dp_status_t status,
    output logic [16:0]         likelihood,
    output logic                rejected
);
    import lhl_pkg::*;

    // Probability table, one entry per row, last layer and layer.
    logic [PROB_W-1:0] table_mem [0:TABLE_DEPTH-1];

    // Track operands, taken when an evaluate item is accepted.
    logic [ROW_W-1:0]   row_reg;
    logic [LAST_W-1:0]  last_reg;
    logic signed [4:0]  barrel_reg;
    logic signed [4:0]  endcap_reg;
    logic [28:0]        crossed_reg;
    logic [28:0]        hit_reg;
    logic               fwd_reg;
    logic               reject_reg;

    // Walk and multiply stages.
    logic [LAYER_W-1:0] pos_reg;
    logic [LAYER_W-1:0] pos_next;
    layer_act_t         act_reg;
    logic               act_valid_reg;
    logic [PROB_W-1:0]  rdata_reg;
    logic [PROB_W-1:0]  pdf_reg;
    logic [PROB_W-1:0]  pdf_next;

    // Operand decode.
    logic               bad_outcome;
    logic               too_high;
    logic               endcap_outcome;
    logic signed [4:0]  last_sel;
    logic               reject_next;
    logic [ROW_W-1:0]   row_next;

    // Per-position decode.
    logic [LAYER_W-1:0] end_l;
    logic               in_barrel;
    logic               active;
    logic               counted;
    logic [30:0]        hit_pad;
    logic               hit_prev;
    logic               hit_next;
    layer_act_t         act_next;
    logic [LAYER_W-1:0] rd_layer;
    logic [ADDR_W-1:0]  rd_addr;
    int                 max_end;

    // Load port.
    logic [PROB_W-1:0]  wr_data;
    logic [ADDR_W-1:0]  wr_addr;
    logic               wr_en;

    logic [PROB_W-1:0]      factor;
    logic [2*PROB_W-1:0]    product;

    assign wr_data = (entry_probability > ONE_FX) ? ONE_FX : entry_probability;
    assign wr_addr = {entry_outcome, entry_last_layer, entry_layer};
    assign wr_en   = cmd.load && (int'(entry_outcome) < ROWS);

    always_comb
    begin
        bad_outcome    = (track_outcome == OUT_NONE) || (track_outcome > OUT_ENDCAP_EXIT);
        too_high       = (int'(barrel_last_layer) > MAX_BARREL_LAYER) ||
                         (int'(endcap_last_layer) > MAX_FORWARD_LAYER);
        endcap_outcome = (track_outcome == OUT_ENDCAP_STOP) ||
                         (track_outcome == OUT_ENDCAP_EXIT);
        last_sel       = endcap_outcome ? endcap_last_layer : barrel_last_layer;
        reject_next    = bad_outcome || too_high || last_sel[4];
        row_next       = ROW_W'(track_outcome);
        if (endcap_outcome)
        begin
            if (barrel_last_layer[4])
            begin
                if (track_outcome == OUT_ENDCAP_STOP)
                begin
                    row_next = is_forward ? ROW_FWD_STOP : ROW_BWD_STOP;
                end
                else
                begin
                    row_next = is_forward ? ROW_FWD_EXIT : ROW_BWD_EXIT;
                end
            end
            else if (track_outcome == OUT_ENDCAP_STOP)
            begin
                row_next = (is_forward ? ROW_FWD_STOP_BASE : ROW_BWD_STOP_BASE) +
                           ROW_W'(barrel_last_layer[3:0]);
            end
            else
            begin
                row_next = (is_forward ? ROW_FWD_EXIT_BASE : ROW_BWD_EXIT_BASE) +
                           ROW_W'(barrel_last_layer[3:0]);
            end
        end
    end

    // Decide the factor for the layer at the current position. Barrel layers
    // come first, then endcap layers from bit BARREL_LAYERS on.
    always_comb
    begin
        end_l     = pos_reg - LAYER_W'(BARREL_LAYERS);
        in_barrel = int'(pos_reg) <= MAX_BARREL_LAYER;
        max_end   = fwd_reg ? MAX_FORWARD_LAYER : MAX_BACKWARD_LAYER;
        hit_pad   = {1'b0, hit_reg, 1'b0};
        hit_prev  = hit_pad[pos_reg];
        hit_next  = hit_pad[LAYER_W'(pos_reg + LAYER_W'(2))];
        if (in_barrel)
        begin
            active  = int'(pos_reg) <= int'(barrel_reg);
            counted = (pos_reg == '0 && row_reg < ROW_FWD_STOP_BASE) ||
                      (int'(pos_reg) == MAX_BARREL_LAYER) ||
                      (int'(pos_reg) < int'(barrel_reg));
        end
        else
        begin
            active  = int'(end_l) <= int'(endcap_reg);
            counted = (end_l == '0) || (int'(end_l) == max_end) ||
                      (int'(end_l) < int'(endcap_reg));
        end
        act_next = ACT_SKIP;
        rd_layer = pos_reg;
        if (active && crossed_reg[pos_reg])
        begin
            if (hit_reg[pos_reg])
            begin
                act_next = ACT_HIT;
            end
            else if (counted)
            begin
                if (hit_prev && hit_next)
                begin
                    // A single missing hit between two hits takes the
                    // neighbor layer's probability.
                    act_next = ACT_HIT;
                    rd_layer = pos_reg - LAYER_W'(1);
                end
                else
                begin
                    act_next = ACT_MISS;
                end
            end
        end
        rd_addr = {row_reg, last_reg, rd_layer};
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rdata_reg <= table_mem[rd_addr];
    end

    assign factor   = (act_reg == ACT_MISS) ? (ONE_FX - rdata_reg) : rdata_reg;
    assign product  = pdf_reg * factor;
    assign pos_next = pos_reg + LAYER_W'(1);

    always_comb
    begin
        pdf_next = pdf_reg;
        if (cmd.capture)
        begin
            pdf_next = ONE_FX;
        end
        else if (act_valid_reg && act_reg != ACT_SKIP)
        begin
            pdf_next = product[FRACTION_BITS +: PROB_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg     <= row_next;
            last_reg    <= last_sel[3:0];
            barrel_reg  <= barrel_last_layer;
            endcap_reg  <= endcap_last_layer;
            crossed_reg <= crossed_pattern;
            hit_reg     <= hit_pattern;
            fwd_reg     <= is_forward;
        end
        act_reg <= act_next;
        pdf_reg <= pdf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            act_valid_reg <= 1'b0;
            reject_reg    <= 1'b0;
        end
        else
        begin
            act_valid_reg <= cmd.step;
            if (cmd.capture)
            begin
                pos_reg    <= '0;
                reject_reg <= reject_next;
            end
            else if (cmd.step)
            begin
                pos_reg <= pos_next;
            end
        end
    end

    assign status.reject    = reject_reg;
    assign status.walk_last = int'(pos_reg) == LAST_POS;
    assign likelihood       = reject_reg ? '0 : pdf_reg;
    assign rejected         = reject_reg;

endmodule
